/* src/tfcc_pkg.sv */
// Shared types and constants for the telemetry frame CRC checker.
// Used by tfcc_crc_byte and telemetry_frame_crc_checker_unit.
package tfcc_pkg;

  localparam int unsigned MaxFrameBytes = 8191;
  localparam int unsigned CountWidth    = 13;
  localparam logic [CountWidth-1:0] CountCap =
      (MaxFrameBytes > 8191) ? 13'd8191 : CountWidth'(MaxFrameBytes);
  localparam logic [CountWidth-1:0] MinFrame      = 13'd13;
  localparam logic [CountWidth-1:0] FrameOverhead = 13'd17;
  localparam logic [CountWidth-1:0] LenHiPos      = 13'd11;
  localparam logic [CountWidth-1:0] LenLoPos      = 13'd12;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  StartReset = 8'd126;

  typedef enum logic [0:0] {
    CFG_START_FIRST  = 1'b0,
    CFG_START_SECOND = 1'b1
  } tfcc_cfg_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_START_ERR = 2'd2,
    ST_LEN_ERR  = 2'd3
  } tfcc_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } tfcc_in_t;

  typedef struct packed {
    tfcc_status_e          status;
    logic [15:0]           computed_crc;
    logic [CountWidth-1:0] frame_length;
  } tfcc_out_t;

endpackage

/* src/tfcc_crc_byte.sv */
// One-byte CRC-16/MODBUS update (reflected, polynomial 0xA001).
// Depends on tfcc_pkg for the polynomial.
module tfcc_crc_byte (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);
  import tfcc_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, byte_i};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

/* src/telemetry_frame_crc_checker_unit.sv */
// Top level of the telemetry frame CRC checker: frame state and result register.
// Depends on tfcc_pkg and tfcc_crc_byte.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (tfcc_in_t)
//   out     | output    | out_valid_o / out_ready_i | out_data_o (tfcc_out_t)
//   cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One word per cycle while ready; a result shows the cycle after its last byte.
// The CRC byte update, frame checks and status select sit between the frame
// state registers and the result register.
// Reset clears the frame state and loads both start bytes with 126.
// A new word is taken while the result register is empty or being drained.
module telemetry_frame_crc_checker_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tfcc_pkg::tfcc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tfcc_pkg::tfcc_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i
);
  import tfcc_pkg::*;

  logic [7:0]            start_first_q, start_second_q;
  logic [15:0]           crc_q, crc_d;
  logic [7:0]            dly0_q, dly0_d, dly1_q, dly1_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  start_ok_q, start_ok_d;
  logic [11:0]           len_field_q, len_field_d;
  logic                  over_q, over_d;
  logic                  out_valid_q, out_valid_d;
  tfcc_out_t             out_data_q, out_data_d;

  logic                  in_fire;
  logic [15:0]           crc_fed, crc_cur;
  logic [CountWidth-1:0] len_new, body_len;
  logic [15:0]           rx_crc;
  tfcc_status_e          status;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  tfcc_crc_byte u_crc (
    .crc_i  (crc_q),
    .byte_i (dly1_q),
    .crc_o  (crc_fed)
  );

  always_comb begin
    logic       ok;
    logic [11:0] lf;
    logic [CountWidth-1:0] n;
    n  = cnt_q;
    ok = start_ok_q;
    lf = len_field_q;
    // the CRC trails the input by two bytes so the trailer stays out of it
    crc_cur = (n >= 13'd2) ? crc_fed : crc_q;
    if (n == 13'd0 && in_data_i.data_byte != start_first_q) ok = 1'b0;
    if (n == 13'd1 && in_data_i.data_byte != start_second_q) ok = 1'b0;
    if (n == LenHiPos) lf = {in_data_i.data_byte[3:0], lf[7:0]};
    if (n == LenLoPos) lf = {lf[11:8], in_data_i.data_byte};
    len_new  = (n < CountCap) ? n + 13'd1 : n;
    over_d   = over_q | (n >= CountCap);
    body_len = len_new - FrameOverhead;
    rx_crc   = {dly0_q, in_data_i.data_byte};

    if (len_new < MinFrame || over_d) begin
      status = ST_LEN_ERR;
    end else if (crc_cur != rx_crc) begin
      status = ST_CRC_ERR;
    end else if (!ok) begin
      status = ST_START_ERR;
    end else if (len_new < FrameOverhead || {1'b0, lf} != body_len) begin
      status = ST_LEN_ERR;
    end else begin
      status = ST_OK;
    end

    crc_d       = crc_q;
    dly0_d      = dly0_q;
    dly1_d      = dly1_q;
    cnt_d       = cnt_q;
    start_ok_d  = start_ok_q;
    len_field_d = len_field_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    if (in_fire) begin
      if (in_data_i.last_byte) begin
        // close the frame: emit the result and clear for the next one
        out_valid_d             = 1'b1;
        out_data_d.status       = status;
        out_data_d.computed_crc = crc_cur;
        out_data_d.frame_length = len_new;
        crc_d       = CrcInit;
        dly0_d      = 8'h00;
        dly1_d      = 8'h00;
        cnt_d       = '0;
        start_ok_d  = 1'b1;
        len_field_d = '0;
      end else begin
        crc_d       = crc_cur;
        dly1_d      = dly0_q;
        dly0_d      = in_data_i.data_byte;
        cnt_d       = len_new;
        start_ok_d  = ok;
        len_field_d = lf;
      end
    end
  end

  logic over_next;
  assign over_next = in_fire ? (over_d && !in_data_i.last_byte) : over_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_first_q  <= StartReset;
      start_second_q <= StartReset;
      crc_q          <= CrcInit;
      dly0_q         <= 8'h00;
      dly1_q         <= 8'h00;
      cnt_q          <= '0;
      start_ok_q     <= 1'b1;
      len_field_q    <= '0;
      over_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_FIRST:  start_first_q  <= cfg_wdata_i;
          CFG_START_SECOND: start_second_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      crc_q       <= crc_d;
      dly0_q      <= dly0_d;
      dly1_q      <= dly1_d;
      cnt_q       <= cnt_d;
      start_ok_q  <= start_ok_d;
      len_field_q <= len_field_d;
      over_q      <= over_next;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

`ifndef SYNTH
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o) else $error("input stalled with empty result register");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last_byte) |=> out_valid_o)
    else $error("last byte taken without a result");

  a_frame_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.last_byte) |=> (cnt_q == '0 && crc_q == CrcInit && !over_q))
    else $error("frame state not cleared after last byte");

  a_count_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountCap) else $error("byte count above cap");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for telemetry_frame_crc_checker_unit: CRC-16/MODBUS frame checks.
// Depends on tfcc_pkg and the checker RTL. It predicts each frame verdict and compares
// every result word field by field.
`timescale 1ns / 1ps

module testbench;
  import tfcc_pkg::*;

  typedef logic [7:0] frame_bytes_t[$];

  typedef enum int {
    FR_GOOD,
    FR_BAD_CRC,
    FR_BAD_START,
    FR_BAD_LEN,
    FR_NOISE
  } frame_kind_e;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 4;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  tfcc_in_t  in_data     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  tfcc_out_t out_data;
  logic      cfg_we      = 1'b0;
  logic [0:0] cfg_idx    = CFG_START_FIRST;
  logic [7:0] cfg_wdata  = '0;

  // Knobs for the current phase, in percent per cycle.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Checker's copy of the configuration and of the frame state.
  logic [7:0]            start_first  = StartReset;
  logic [7:0]            start_second = StartReset;
  logic [15:0]           crc_acc      = CrcInit;
  logic [7:0]            newest_byte  = '0;
  logic [7:0]            older_byte   = '0;
  logic [CountWidth-1:0] bytes_in_frame = '0;
  logic                  start_match  = 1'b1;
  logic [11:0]           body_len_field = '0;
  logic                  count_capped = 1'b0;

  tfcc_out_t   expected_verdicts[$];
  int unsigned error_count   = 0;
  int unsigned bytes_taken   = 0;
  int unsigned frames_judged = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};
  int unsigned config_settings = 1;
  int unsigned quiet_cycles  = 0;

  telemetry_frame_crc_checker_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [15:0] crc16_modbus_byte(logic [15:0] crc, logic [7:0] b);
    crc = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    end
    return crc;
  endfunction

  function automatic logic [15:0] crc16_modbus_span(ref frame_bytes_t f, input int n);
    logic [15:0] crc;
    crc = CrcInit;
    for (int i = 0; i < n; i++) begin
      crc = crc16_modbus_byte(crc, f[i]);
    end
    return crc;
  endfunction

  // Advance the frame state by one byte; on the last byte queue the verdict.
  function automatic void predict_frame_byte(logic [7:0] b, logic last);
    tfcc_out_t verdict;
    logic [15:0] rx_crc;
    if (bytes_in_frame >= 2) crc_acc = crc16_modbus_byte(crc_acc, older_byte);
    if (bytes_in_frame == 0 && b != start_first) start_match = 1'b0;
    if (bytes_in_frame == 1 && b != start_second) start_match = 1'b0;
    if (bytes_in_frame == LenHiPos) body_len_field[11:8] = b[3:0];
    if (bytes_in_frame == LenLoPos) body_len_field[7:0] = b;
    older_byte  = newest_byte;
    newest_byte = b;
    if (bytes_in_frame < CountCap) bytes_in_frame = bytes_in_frame + 1'b1;
    else count_capped = 1'b1;
    if (!last) return;

    rx_crc = {older_byte, newest_byte};
    if (bytes_in_frame < MinFrame || count_capped) begin
      verdict.status = ST_LEN_ERR;
    end else if (crc_acc != rx_crc) begin
      verdict.status = ST_CRC_ERR;
    end else if (!start_match) begin
      verdict.status = ST_START_ERR;
    end else if (bytes_in_frame < FrameOverhead ||
                 {1'b0, body_len_field} != bytes_in_frame - FrameOverhead) begin
      verdict.status = ST_LEN_ERR;
    end else begin
      verdict.status = ST_OK;
    end
    verdict.computed_crc = crc_acc;
    verdict.frame_length = bytes_in_frame;
    expected_verdicts.push_back(verdict);

    crc_acc        = CrcInit;
    newest_byte    = '0;
    older_byte     = '0;
    bytes_in_frame = '0;
    start_match    = 1'b1;
    body_len_field = '0;
    count_capped   = 1'b0;
  endfunction

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Predict on every accepted byte, then check every accepted result word.
  always @(posedge clk_i) begin
    tfcc_out_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        bytes_taken++;
        predict_frame_byte(in_data.data_byte, in_data.last_byte);
      end
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          error_count++;
          $display("%0t: result word with nothing expected: status %0d crc %04h len %0d",
                   $time, out_data.status, out_data.computed_crc, out_data.frame_length);
        end else begin
          want = expected_verdicts.pop_front();
          frames_judged++;
          status_seen[want.status]++;
          if (out_data.status !== want.status) begin
            error_count++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_data.status);
          end
          if (out_data.computed_crc !== want.computed_crc) begin
            error_count++;
            $display("%0t: computed_crc mismatch: expected %04h, actual %04h",
                     $time, want.computed_crc, out_data.computed_crc);
          end
          if (out_data.frame_length !== want.frame_length) begin
            error_count++;
            $display("%0t: frame_length mismatch: expected %0d, actual %0d",
                     $time, want.frame_length, out_data.frame_length);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, WatchdogLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Hold valid high with the payload until the byte is taken.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: last};
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_frame(frame_bytes_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
  endtask

  // Drop valid, drain every expected result, then let trailing work settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_start_bytes(logic [7:0] first, logic [7:0] second);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_START_FIRST;
    cfg_wdata <= first;
    @(posedge clk_i);
    start_first = first;
    cfg_idx   <= CFG_START_SECOND;
    cfg_wdata <= second;
    @(posedge clk_i);
    start_second = second;
    cfg_we <= 1'b0;
    config_settings++;
  endtask

  // Build a body_len + 17 byte frame with CRC trailer, corrupted as asked, or noise.
  function automatic void build_frame(ref frame_bytes_t f, input int body_len,
                                      input frame_kind_e kind);
    logic [11:0] len12;
    logic [15:0] crc;
    int total;
    f.delete();
    if (kind == FR_NOISE) begin
      total = $urandom_range(1, 40);
      repeat (total) f.push_back(8'($urandom));
      return;
    end
    len12 = body_len[11:0];
    total = body_len + 17;
    f.push_back(start_first);
    f.push_back(start_second);
    for (int i = 2; i < 11; i++) f.push_back(8'($urandom));
    f.push_back({4'($urandom), len12[11:8]});
    f.push_back(len12[7:0]);
    while (f.size() < total - 2) f.push_back(8'($urandom));
    if (kind == FR_BAD_START) begin
      if ($urandom_range(1)) f[0] = f[0] ^ 8'($urandom_range(1, 255));
      else f[1] = f[1] ^ 8'($urandom_range(1, 255));
    end
    if (kind == FR_BAD_LEN) f[12] = f[12] ^ 8'($urandom_range(1, 255));
    crc = crc16_modbus_span(f, total - 2);
    if (kind == FR_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
    f.push_back(crc[15:8]);
    f.push_back(crc[7:0]);
  endfunction

  task automatic test_directed();
    frame_bytes_t f;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_frame('{8'hFF});
    send_frame('{8'h00, 8'hFF});
    build_frame(f, 0, FR_GOOD);
    send_frame(f);
    wait_idle();
  endtask

  // Lengths 1 to 16 (below overhead): start bytes, matching trailer from 4 bytes on.
  task automatic test_small_lengths();
    frame_bytes_t f;
    logic [15:0] crc;
    for (int n = 1; n <= 16; n++) begin
      f.delete();
      f.push_back(start_first);
      f.push_back(start_second);
      while (f.size() < n) f.push_back(8'($urandom));
      while (f.size() > n) void'(f.pop_back());
      if (n >= 4) begin
        crc = crc16_modbus_span(f, n - 2);
        f[n-2] = crc[15:8];
        f[n-1] = crc[7:0];
      end
      send_frame(f);
    end
    wait_idle();
  endtask

  task automatic test_each_error();
    frame_bytes_t f;
    build_frame(f, 3, FR_BAD_CRC);
    send_frame(f);
    build_frame(f, 5, FR_BAD_START);
    send_frame(f);
    build_frame(f, 1, FR_BAD_LEN);
    send_frame(f);
    wait_idle();
  endtask

  task automatic test_random_traffic(int unsigned n_bytes, int unsigned idle_pct,
                                     int unsigned stall_pct);
    frame_bytes_t f;
    frame_kind_e kind;
    int unsigned pick;
    int unsigned sent;
    int body;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      kind = (pick < 60) ? FR_GOOD : (pick < 70) ? FR_BAD_CRC :
             (pick < 80) ? FR_BAD_START : (pick < 90) ? FR_BAD_LEN : FR_NOISE;
      body = ($urandom_range(19) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
      build_frame(f, body, kind);
      send_frame(f);
      sent += f.size();
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_small_lengths();
    test_each_error();

    set_start_bytes(8'h00, 8'hFF);
    test_each_error();
    test_random_traffic(200, 0, 0);
    set_start_bytes(8'hFF, 8'h00);
    test_random_traffic(200, 57, 0);
    set_start_bytes(8'($urandom), 8'($urandom));
    test_random_traffic(200, 0, 57);
    set_start_bytes(StartReset, StartReset);
    test_random_traffic(200, 25, 25);

    if (expected_verdicts.size() != 0) begin
      error_count++;
      $display("%0t: %0d results never arrived", $time, expected_verdicts.size());
    end
    $display("Judged %0d frames from %0d bytes under %0d start-byte settings.",
             frames_judged, bytes_taken, config_settings);
    $display("Verdicts: %0d ok, %0d crc, %0d start, %0d length; %0d field errors.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
